// ===== hdl/bklk_pkg.sv =====
// bklk_pkg: shared types and codes for the bakery ticket lock arbiter.
// Depends on nothing; imported by bklk_store and bakery_ticket_lock_arbiter.
package bklk_pkg;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_QUEUED   = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	localparam logic REQ_LOCK   = 1'b0;
	localparam logic REQ_UNLOCK = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

endpackage

// ===== hdl/bklk_store.sv =====
// bklk_store: ticket table, one write and one registered read port per cycle.
// Per-entry valid bits make every entry read as zero after reset. Uses bklk_pkg.
module bklk_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	import bklk_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/bakery_ticket_lock_arbiter.sv =====
// bakery_ticket_lock_arbiter: top level, request sequencer and holder scan.
// Depends on bklk_pkg and bklk_store.
//
//   channel  signals                                          direction
//   in       in_valid, in_stall, req_type, requester          request words in
//   out      out_valid, out_stall, ticket, holder_valid,      result words out
//            holder_thread, status
//   cfg      cfg_we, cfg_wdata                                thread_count write
//
// Each word is accepted in S_IDLE, then S_SCAN streams the ticket table through
// the single read port, one entry per active thread, and S_FIN writes back.
// Reset clears the table at once through per-entry valid bits; no sweep.
// A result waits in the output register while the next word is scanned; the
// write-back cycle holds while that register is still full and stalled.
module bakery_ticket_lock_arbiter #(
	parameter int MAX_THREADS  = 16,
	parameter int TICKET_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [3:0] requester,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [15:0] ticket,
	output logic       holder_valid,
	output logic [3:0] holder_thread,
	output logic [1:0] status,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);
	import bklk_pkg::*;

	localparam int IDX_W = $clog2(MAX_THREADS);
	localparam int CNT_W = $clog2(MAX_THREADS + 1);

	state_t state_q, state_d;

	logic [4:0]              thread_count_q;
	logic [CNT_W-1:0]        n_eff;
	logic                    accept;
	logic                    in_range;

	logic                    req_q;
	logic [3:0]              tid_q;
	logic                    in_range_q;
	logic [IDX_W-1:0]        tid_idx;

	logic [CNT_W-1:0]        issue_q;
	logic                    issue_more;
	logic                    pend_s1;
	logic [IDX_W-1:0]        idx_s1;

	logic [TICKET_WIDTH-1:0] rd_data;
	logic [TICKET_WIDTH-1:0] top_q, own_q, best_q;
	logic [IDX_W-1:0]        who_q;
	logic                    found_q;

	logic                    rd_en, wr_en, fin_go;
	logic [TICKET_WIDTH-1:0] new_val;
	logic [1:0]              stat_d;
	logic                    hold_self;

	logic                    out_valid_q;
	logic [15:0]             ticket_q;
	logic                    holder_valid_q;
	logic [3:0]              holder_thread_q;
	logic [1:0]              status_q;

	assign n_eff = (32'(thread_count_q) > MAX_THREADS) ? CNT_W'(MAX_THREADS)
		: CNT_W'(thread_count_q);
	assign in_range   = 32'(requester) < 32'(n_eff);
	assign accept     = in_valid && !in_stall;
	assign tid_idx    = IDX_W'(tid_q);
	assign issue_more = issue_q < n_eff;
	assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	bklk_store #(
		.DEPTH(MAX_THREADS),
		.WIDTH(TICKET_WIDTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(issue_q[IDX_W-1:0]),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(tid_idx),
		.wr_data(new_val)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!issue_more) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		case (state_q)
			S_IDLE:  in_stall = 1'b0;
			S_SCAN:  rd_en = issue_more;
			S_FIN:   rd_en = 1'b0;
			default: in_stall = 1'b1;
		endcase
	end

	// final value of the requesting entry and the word's status
	always_comb begin
		new_val = '0;
		stat_d  = STAT_OK;
		wr_en   = 1'b0;
		if (!in_range_q) begin
			stat_d = STAT_RANGE;
		end else if (req_q == REQ_UNLOCK) begin
			wr_en = fin_go;
		end else if (own_q != '0) begin
			stat_d  = STAT_QUEUED;
			new_val = own_q;
		end else if (&top_q) begin
			stat_d = STAT_OVERFLOW;
		end else begin
			new_val = top_q + TICKET_WIDTH'(1);
			wr_en   = fin_go;
		end
	end

	assign hold_self = (new_val != '0) && (!found_q || new_val < best_q
		|| (new_val == best_q && tid_idx < who_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			thread_count_q <= 5'd16;
			issue_q        <= '0;
			pend_s1        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				thread_count_q <= cfg_wdata;
			end
			if (accept) begin
				issue_q <= '0;
			end else if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			pend_s1 <= rd_en;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		if (accept) begin
			req_q      <= req_type;
			tid_q      <= requester;
			in_range_q <= in_range;
			top_q      <= '0;
			own_q      <= '0;
			best_q     <= '0;
			who_q      <= '0;
			found_q    <= 1'b0;
		end else if (pend_s1) begin
			if (rd_data > top_q) begin
				top_q <= rd_data;
			end
			if (in_range_q && idx_s1 == tid_idx) begin
				own_q <= rd_data;
			end else if (rd_data != '0 && (!found_q || rd_data < best_q)) begin
				best_q  <= rd_data;
				who_q   <= idx_s1;
				found_q <= 1'b1;
			end
		end
		if (fin_go) begin
			ticket_q       <= (stat_d == STAT_OK && req_q == REQ_LOCK)
				? 16'(new_val) : 16'd0;
			status_q       <= stat_d;
			holder_valid_q <= hold_self || found_q;
			holder_thread_q <= hold_self ? tid_q : (found_q ? 4'(who_q) : 4'd0);
		end
	end

	assign out_valid     = out_valid_q;
	assign ticket        = ticket_q;
	assign holder_valid  = holder_valid_q;
	assign holder_thread = holder_thread_q;
	assign status        = status_q;

	a_err_no_ticket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> ticket == 16'd0)
		else $error("ticket given on a rejected request");

	a_no_holder_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !holder_valid |-> holder_thread == 4'd0)
		else $error("holder id without a holder");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("input taken while busy");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN)
		else $error("accepted word did not start a scan");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> state_q == S_IDLE && out_valid)
		else $error("table write outside write-back");

endmodule
